/* rtl/core/jhs_pkg.sv */
// Shared types and codes for the 3D Jacobi heat stencil block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none
package jhs_pkg;

	typedef struct packed {
		logic [1:0]  action;
		logic [14:0] cell_index;
		logic [31:0] density;
		logic [31:0] energy;
	} jhs_in_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [47:0]        error_sum;
		logic               fault;
	} jhs_out_t;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_INIT  = 2'd1;
	localparam logic [1:0] ACT_SWEEP = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RECIP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z = 3'd6;

endpackage
`default_nettype wire

/* rtl/core/jhs_mul.sv */
// Shared 32x32 unsigned multiplier with a registered product.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module jhs_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);
	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;
endmodule
`default_nettype wire

/* rtl/core/jhs_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; a start beat loads the operands, done pulses with the quotient.
`timescale 1ns / 1ps
`default_nettype none
module jhs_div #(
	parameter int NW = 82,
	parameter int DW = 66
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   shifted;
	logic          ge;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= ge ? DW'(shifted - {1'b0, den_q}) : DW'(shifted);
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

/* rtl/core/jacobi_heat_stencil_3d.sv */
// Implicit heat-conduction solver on a 3D grid (7-point Jacobi stencil, Q16.16 by default).
// Depends on jhs_pkg, jhs_mul and jhs_div.
//
// One item is taken at a time; in_ready is high only while the sequencer is idle, and a
// finished result waits in the output register while the next item is accepted. Init first
// walks every cell inside the outer layer (read, multiply, write), then for each coefficient
// cell makes 4 density fetches and up to 7 divisions (4 reciprocals in recip mode, 3 face
// coefficients) on the shared restoring divider, whose numerator is NW = 66+FRAC_BITS bits
// (82 by default). A sweep copies the grid at one cell per cycle, then updates each interior
// cell with six serial multiply-accumulates on the shared multiplier and one division.
// Stores are not cleared by reset; cells must be loaded before init, and init run before sweep.
`timescale 1ns / 1ps
`default_nettype none
module jacobi_heat_stencil_3d #(
	parameter int MAX_CELLS = 32768,
	parameter int HALO      = 2,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  jhs_pkg::jhs_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output jhs_pkg::jhs_out_t            out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [jhs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                  cfg_data
);
	import jhs_pkg::*;

	localparam int AW = $clog2(MAX_CELLS);
	localparam int NW = 66 + FRAC_BITS;
	localparam int DW = 66;

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_RD      = 5'd1;
	localparam logic [4:0] ST_DONE    = 5'd2;
	localparam logic [4:0] ST_IA_RD   = 5'd3;
	localparam logic [4:0] ST_IA_MUL  = 5'd4;
	localparam logic [4:0] ST_IA_WR   = 5'd5;
	localparam logic [4:0] ST_IB_RD   = 5'd6;
	localparam logic [4:0] ST_IB_EFF  = 5'd7;
	localparam logic [4:0] ST_IB_EDIV = 5'd8;
	localparam logic [4:0] ST_IB_FA   = 5'd9;
	localparam logic [4:0] ST_IB_FB   = 5'd10;
	localparam logic [4:0] ST_IB_FC   = 5'd11;
	localparam logic [4:0] ST_IB_FD   = 5'd12;
	localparam logic [4:0] ST_IB_FDIV = 5'd13;
	localparam logic [4:0] ST_SC_RUN  = 5'd14;
	localparam logic [4:0] ST_SW_RD0  = 5'd15;
	localparam logic [4:0] ST_SW_INIT = 5'd16;
	localparam logic [4:0] ST_SW_RD   = 5'd17;
	localparam logic [4:0] ST_SW_MUL  = 5'd18;
	localparam logic [4:0] ST_SW_ACC  = 5'd19;
	localparam logic [4:0] ST_SW_DIV  = 5'd20;
	localparam logic [4:0] ST_SW_DW   = 5'd21;

	// configuration
	logic [5:0]  sx_q, sy_q, sz_q;
	logic        recip_q;
	logic [31:0] scx_q, scy_q, scz_q;

	// sequencer
	logic [4:0]  st_q, st_d;
	logic        ov_q;
	jhs_out_t    out_q;
	logic        in_acc;

	// result accumulation
	logic [31:0] rv_q;
	logic [47:0] err_q;
	logic        fault_q;
	logic        rd_ok_q;

	// grid geometry
	logic [11:0]   page;
	logic [17:0]   total;
	logic          fits;
	logic [AW-1:0] page_a, sx_a;

	// cell walk
	logic [5:0]        x_q, y_q, z_q;
	logic [2:0]        lo_q, woff_q;
	logic [AW-1:0]     row_q, plane_q;
	logic signed [7:0] ex, ey, ez;
	logic              x_more, y_more, z_more, walk_last;
	logic              walk_adv, walk_ld;
	logic [2:0]        ld_lo, ld_off;
	logic              empty_a, empty_b, empty_s;
	logic [AW-1:0]     cur_i;

	// datapath registers
	logic [1:0]    ksel_q;
	logic [2:0]    j_q;
	logic [31:0]   ec_q, ea_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] pos_q, neg_q;
	logic [31:0]   old_q;
	logic          sgn_q, isneg_q;
	logic [AW:0]   cp_q;
	logic          cp_v_q;
	logic [AW-1:0] cp_wa_q;

	// shared units
	logic [31:0]   mul_a, mul_b;
	logic [63:0]   mul_p;
	logic          div_start, div_done;
	logic [NW-1:0] div_num, div_quo;
	logic [DW-1:0] div_den;

	// memories
	logic [31:0] dens_mem [MAX_CELLS];
	logic [31:0] ener_mem [MAX_CELLS];
	logic [31:0] base_mem [MAX_CELLS];
	logic [31:0] temp_mem [MAX_CELLS];
	logic [31:0] prev_mem [MAX_CELLS];
	logic [31:0] cx_mem   [MAX_CELLS];
	logic [31:0] cy_mem   [MAX_CELLS];
	logic [31:0] cz_mem   [MAX_CELLS];

	logic [31:0]   dens_rd, ener_rd, base_rd, temp_rd, prev_rd, cx_rd, cy_rd, cz_rd;
	logic [AW-1:0] dens_ra, temp_ra, prev_ra, cx_ra, cy_ra, cz_ra;
	logic          ld_we;
	logic [AW-1:0] ld_wa;
	logic          base_we, temp_we, prev_we, cx_we, cy_we, cz_we;
	logic [AW-1:0] temp_wa, prev_wa;
	logic [31:0]   temp_wd;

	// derived values
	logic          idx_ok;
	logic [63:0]   init_p;
	logic [31:0]   init_v;
	logic [31:0]   quo_sat;
	logic [31:0]   eff_v;
	logic          eff_fin, coef_fin;
	logic [31:0]   coef_v;
	logic [31:0]   scale_k;
	logic [31:0]   term_k, term_r, term_mag;
	logic [31:0]   base_mag;
	logic          pos_ge;
	logic [NW-1:0] sw_mag;
	logic [31:0]   sw_qv, sw_out;
	logic signed [32:0] sw_diff;
	logic [32:0]   sw_absd;
	logic [48:0]   err_sum;

	function automatic logic signed [7:0] f_end(input logic [5:0] s, input logic [2:0] off);
		f_end = $signed({2'b00, s}) - $signed({5'b00000, off});
	endfunction

	function automatic logic f_empty(input logic [2:0] lo, input logic [2:0] off);
		logic signed [7:0] lo_s;
		lo_s = $signed({5'b00000, lo});
		f_empty = (f_end(sx_q, off) <= lo_s) || (f_end(sy_q, off) <= lo_s)
			|| (f_end(sz_q, off) <= lo_s);
	endfunction

	function automatic logic [AW-1:0] f_plane(input logic [2:0] lo);
		f_plane = AW'(32'(lo) * 32'(page));
	endfunction

	function automatic logic [AW-1:0] f_losx(input logic [2:0] lo);
		f_losx = AW'(32'(lo) * 32'(sx_q));
	endfunction

	assign page   = 12'(sx_q) * 12'(sy_q);
	assign total  = 18'(page) * 18'(sz_q);
	assign fits   = 32'(total) <= 32'(MAX_CELLS);
	assign page_a = AW'(page);
	assign sx_a   = AW'(sx_q);

	assign ex        = f_end(sx_q, woff_q);
	assign ey        = f_end(sy_q, woff_q);
	assign ez        = f_end(sz_q, woff_q);
	assign x_more    = $signed({2'b00, x_q} + 8'd1) < ex;
	assign y_more    = $signed({2'b00, y_q} + 8'd1) < ey;
	assign z_more    = $signed({2'b00, z_q} + 8'd1) < ez;
	assign walk_last = !x_more && !y_more && !z_more;
	assign empty_a   = f_empty(3'd1, 3'd1);
	assign empty_b   = f_empty(3'(HALO), 3'd1);
	assign empty_s   = f_empty(3'(HALO), 3'(HALO));
	assign cur_i     = row_q + AW'(x_q);

	assign in_ready  = st_q == ST_IDLE;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = ov_q;
	assign out_data  = out_q;
	assign idx_ok    = 32'(in_data.cell_index) < 32'(MAX_CELLS);

	jhs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	jhs_div #(.NW(NW), .DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// arithmetic helpers
	assign init_p   = mul_p >> FRAC_BITS;
	assign init_v   = (|init_p[63:31]) ? 32'h7FFF_FFFF : init_p[31:0];
	assign quo_sat  = (|div_quo[NW-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
	assign eff_v    = (st_q == ST_IB_EDIV) ? quo_sat : (recip_q ? 32'd0 : dens_rd);
	assign eff_fin  = (st_q == ST_IB_EFF && !(recip_q && dens_rd != 32'd0))
		|| (st_q == ST_IB_EDIV && div_done);
	assign coef_fin = (st_q == ST_IB_FD && den_q == '0) || (st_q == ST_IB_FDIV && div_done);
	assign coef_v   = (st_q == ST_IB_FDIV) ? quo_sat : 32'd0;

	always_comb begin
		unique case (ksel_q)
			2'd1:    scale_k = scx_q;
			2'd2:    scale_k = scy_q;
			default: scale_k = scz_q;
		endcase
	end

	always_comb begin
		unique case (j_q)
			3'd0, 3'd1: term_k = cx_rd;
			3'd2, 3'd3: term_k = cy_rd;
			default:    term_k = cz_rd;
		endcase
	end
	assign term_r   = prev_rd;
	assign term_mag = term_r[31] ? (~term_r + 32'd1) : term_r;
	assign base_mag = base_rd[31] ? (~base_rd + 32'd1) : base_rd;

	assign pos_ge = pos_q >= neg_q;
	assign sw_mag = pos_ge ? (pos_q - neg_q) : (neg_q - pos_q);

	always_comb begin
		if (isneg_q) begin
			sw_qv  = ((|div_quo[NW-1:32]) || div_quo[31:0] > 32'h8000_0000)
				? 32'h8000_0000 : div_quo[31:0];
			sw_out = ~sw_qv + 32'd1;
		end else begin
			sw_qv  = (|div_quo[NW-1:31]) ? 32'h7FFF_FFFF : div_quo[31:0];
			sw_out = sw_qv;
		end
	end
	assign sw_diff = $signed({sw_out[31], sw_out}) - $signed({old_q[31], old_q});
	assign sw_absd = sw_diff[32] ? 33'(-sw_diff) : 33'(sw_diff);
	assign err_sum = {1'b0, err_q} + 49'(sw_absd);

	// shared unit operands
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		unique case (st_q)
			ST_IA_MUL: begin
				mul_a = ener_rd;
				mul_b = dens_rd;
			end
			ST_IB_FA: begin
				mul_a = ea_q;
				mul_b = ec_q;
			end
			ST_IB_FB: begin
				mul_a = scale_k;
				mul_b = ea_q;
			end
			ST_IB_FC: begin
				mul_a = scale_k;
				mul_b = ec_q;
			end
			ST_SW_MUL: begin
				mul_a = term_k;
				mul_b = term_mag;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (st_q)
			ST_IB_EFF: begin
				div_start = recip_q && dens_rd != 32'd0;
				div_num   = NW'(1) << (2 * FRAC_BITS);
				div_den   = DW'(dens_rd);
			end
			ST_IB_FD: begin
				div_start = den_q != '0;
				div_num   = (pos_q + NW'(mul_p)) << FRAC_BITS;
				div_den   = den_q;
			end
			ST_SW_DIV: begin
				div_start = 1'b1;
				div_num   = sw_mag;
				div_den   = den_q;
			end
			default: begin
			end
		endcase
	end

	// next state and walk strobes
	always_comb begin
		st_d     = st_q;
		walk_adv = 1'b0;
		walk_ld  = 1'b0;
		ld_lo    = 3'd1;
		ld_off   = 3'd1;
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (in_data.action)
						ACT_LOAD: st_d = ST_DONE;
						ACT_READ: st_d = ST_RD;
						ACT_INIT: begin
							if (!fits) begin
								st_d = ST_DONE;
							end else if (!empty_a) begin
								walk_ld = 1'b1;
								st_d    = ST_IA_RD;
							end else if (!empty_b) begin
								walk_ld = 1'b1;
								ld_lo   = 3'(HALO);
								st_d    = ST_IB_RD;
							end else begin
								st_d = ST_DONE;
							end
						end
						default: st_d = fits ? ST_SC_RUN : ST_DONE;
					endcase
				end
			end
			ST_RD:     st_d = ST_DONE;
			ST_IA_RD:  st_d = ST_IA_MUL;
			ST_IA_MUL: st_d = ST_IA_WR;
			ST_IA_WR: begin
				if (!walk_last) begin
					walk_adv = 1'b1;
					st_d     = ST_IA_RD;
				end else if (!empty_b) begin
					walk_ld = 1'b1;
					ld_lo   = 3'(HALO);
					st_d    = ST_IB_RD;
				end else begin
					st_d = ST_DONE;
				end
			end
			ST_IB_RD: st_d = ST_IB_EFF;
			ST_IB_EFF, ST_IB_EDIV: begin
				if (st_q == ST_IB_EFF && recip_q && dens_rd != 32'd0) begin
					st_d = ST_IB_EDIV;
				end else if (eff_fin) begin
					st_d = (ksel_q == 2'd0) ? ST_IB_RD : ST_IB_FA;
				end
			end
			ST_IB_FA: st_d = ST_IB_FB;
			ST_IB_FB: st_d = ST_IB_FC;
			ST_IB_FC: st_d = ST_IB_FD;
			ST_IB_FD, ST_IB_FDIV: begin
				if (st_q == ST_IB_FD && den_q != '0) begin
					st_d = ST_IB_FDIV;
				end else if (coef_fin) begin
					if (ksel_q != 2'd3) begin
						st_d = ST_IB_RD;
					end else if (walk_last) begin
						st_d = ST_DONE;
					end else begin
						walk_adv = 1'b1;
						st_d     = ST_IB_RD;
					end
				end
			end
			ST_SC_RUN: begin
				if (32'(cp_q) >= 32'(total) && !cp_v_q) begin
					if (empty_s) begin
						st_d = ST_DONE;
					end else begin
						walk_ld = 1'b1;
						ld_lo   = 3'(HALO);
						ld_off  = 3'(HALO);
						st_d    = ST_SW_RD0;
					end
				end
			end
			ST_SW_RD0:  st_d = ST_SW_INIT;
			ST_SW_INIT: st_d = ST_SW_RD;
			ST_SW_RD:   st_d = ST_SW_MUL;
			ST_SW_MUL:  st_d = ST_SW_ACC;
			ST_SW_ACC:  st_d = (j_q == 3'd5) ? ST_SW_DIV : ST_SW_RD;
			ST_SW_DIV:  st_d = ST_SW_DW;
			ST_SW_DW: begin
				if (div_done) begin
					if (walk_last) begin
						st_d = ST_DONE;
					end else begin
						walk_adv = 1'b1;
						st_d     = ST_SW_RD0;
					end
				end
			end
			ST_DONE: begin
				if (!ov_q || out_ready) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			ov_q    <= 1'b0;
			sx_q    <= 6'd32;
			sy_q    <= 6'd32;
			sz_q    <= 6'd32;
			recip_q <= 1'b0;
			scx_q   <= 32'h0001_0000;
			scy_q   <= 32'h0001_0000;
			scz_q   <= 32'h0001_0000;
			fault_q <= 1'b0;
			cp_v_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_DONE && (!ov_q || out_ready)) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_SIZE_X:  sx_q    <= cfg_data[5:0];
					CFG_SIZE_Y:  sy_q    <= cfg_data[5:0];
					CFG_SIZE_Z:  sz_q    <= cfg_data[5:0];
					CFG_RECIP:   recip_q <= cfg_data[0];
					CFG_SCALE_X: scx_q   <= cfg_data;
					CFG_SCALE_Y: scy_q   <= cfg_data;
					CFG_SCALE_Z: scz_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			if (in_acc) begin
				fault_q <= 1'b0;
			end else if ((st_q == ST_IB_EFF && recip_q && dens_rd == 32'd0)
					|| (st_q == ST_IB_FD && den_q == '0)) begin
				fault_q <= 1'b1;
			end
			if (st_q == ST_SC_RUN) begin
				cp_v_q <= 32'(cp_q) < 32'(total);
			end else begin
				cp_v_q <= 1'b0;
			end
		end
	end

	// walk and datapath registers
	always_ff @(posedge clk) begin
		if (walk_ld) begin
			lo_q    <= ld_lo;
			woff_q  <= ld_off;
			x_q     <= 6'(ld_lo);
			y_q     <= 6'(ld_lo);
			z_q     <= 6'(ld_lo);
			plane_q <= f_plane(ld_lo);
			row_q   <= f_plane(ld_lo) + f_losx(ld_lo);
		end else if (walk_adv) begin
			if (x_more) begin
				x_q <= x_q + 6'd1;
			end else if (y_more) begin
				x_q   <= 6'(lo_q);
				y_q   <= y_q + 6'd1;
				row_q <= row_q + sx_a;
			end else begin
				x_q     <= 6'(lo_q);
				y_q     <= 6'(lo_q);
				z_q     <= z_q + 6'd1;
				plane_q <= plane_q + page_a;
				row_q   <= plane_q + page_a + f_losx(lo_q);
			end
		end

		if (in_acc) begin
			rv_q    <= 32'd0;
			err_q   <= 48'd0;
			rd_ok_q <= idx_ok;
			cp_q    <= '0;
		end
		if (st_q == ST_RD) rv_q <= rd_ok_q ? temp_rd : 32'd0;

		if (walk_ld || walk_adv) begin
			ksel_q <= 2'd0;
		end else if (eff_fin && ksel_q == 2'd0) begin
			ksel_q <= 2'd1;
		end else if (coef_fin && ksel_q != 2'd3) begin
			ksel_q <= ksel_q + 2'd1;
		end
		if (eff_fin) begin
			if (ksel_q == 2'd0) ec_q <= eff_v;
			else ea_q <= eff_v;
		end

		unique case (st_q)
			ST_IB_FB: den_q <= DW'({mul_p, 1'b0});
			ST_IB_FC: pos_q <= NW'(mul_p);
			ST_SW_INIT: begin
				old_q <= prev_rd;
				den_q <= DW'(1) << FRAC_BITS;
				j_q   <= 3'd0;
				pos_q <= base_rd[31] ? '0 : (NW'(base_mag) << FRAC_BITS);
				neg_q <= base_rd[31] ? (NW'(base_mag) << FRAC_BITS) : '0;
			end
			ST_SW_MUL: begin
				den_q <= den_q + DW'(term_k);
				sgn_q <= term_r[31];
			end
			ST_SW_ACC: begin
				if (sgn_q) neg_q <= neg_q + NW'(mul_p);
				else pos_q <= pos_q + NW'(mul_p);
				j_q <= j_q + 3'd1;
			end
			ST_SW_DIV: isneg_q <= !pos_ge;
			ST_SW_DW: begin
				if (div_done) err_q <= err_sum[48] ? 48'hFFFF_FFFF_FFFF : err_sum[47:0];
			end
			ST_SC_RUN: begin
				if (32'(cp_q) < 32'(total)) begin
					cp_q    <= cp_q + (AW+1)'(1);
					cp_wa_q <= cp_q[AW-1:0];
				end
			end
			default: begin
			end
		endcase

		if (st_q == ST_DONE && (!ov_q || out_ready)) begin
			out_q.read_value <= rv_q;
			out_q.error_sum  <= err_q;
			out_q.fault      <= fault_q;
		end
	end

	// memory ports
	assign ld_we = in_acc && in_data.action == ACT_LOAD && idx_ok;
	assign ld_wa = AW'(in_data.cell_index);

	always_comb begin
		unique case (ksel_q)
			2'd0:    dens_ra = cur_i;
			2'd1:    dens_ra = cur_i - AW'(1);
			2'd2:    dens_ra = cur_i - sx_a;
			default: dens_ra = cur_i - page_a;
		endcase
	end

	always_comb begin
		if (st_q == ST_IDLE) temp_ra = AW'(in_data.cell_index);
		else if (st_q == ST_SC_RUN) temp_ra = cp_q[AW-1:0];
		else temp_ra = cur_i;
	end

	always_comb begin
		prev_ra = cur_i;
		if (st_q == ST_SW_RD) begin
			unique case (j_q)
				3'd0:    prev_ra = cur_i + AW'(1);
				3'd1:    prev_ra = cur_i - AW'(1);
				3'd2:    prev_ra = cur_i + sx_a;
				3'd3:    prev_ra = cur_i - sx_a;
				3'd4:    prev_ra = cur_i + page_a;
				default: prev_ra = cur_i - page_a;
			endcase
		end
	end

	assign cx_ra = (j_q == 3'd0) ? cur_i + AW'(1) : cur_i;
	assign cy_ra = (j_q == 3'd2) ? cur_i + sx_a : cur_i;
	assign cz_ra = (j_q == 3'd4) ? cur_i + page_a : cur_i;

	assign base_we = st_q == ST_IA_WR;
	assign temp_we = st_q == ST_IA_WR || (st_q == ST_SW_DW && div_done);
	assign temp_wa = cur_i;
	assign temp_wd = (st_q == ST_IA_WR) ? init_v : sw_out;
	assign prev_we = st_q == ST_SC_RUN && cp_v_q;
	assign prev_wa = cp_wa_q;
	assign cx_we   = coef_fin && ksel_q == 2'd1;
	assign cy_we   = coef_fin && ksel_q == 2'd2;
	assign cz_we   = coef_fin && ksel_q == 2'd3;

	always_ff @(posedge clk) begin
		if (ld_we) dens_mem[ld_wa] <= in_data.density;
		dens_rd <= dens_mem[dens_ra];
	end

	always_ff @(posedge clk) begin
		if (ld_we) ener_mem[ld_wa] <= in_data.energy;
		ener_rd <= ener_mem[cur_i];
	end

	always_ff @(posedge clk) begin
		if (base_we) base_mem[cur_i] <= init_v;
		base_rd <= base_mem[cur_i];
	end

	always_ff @(posedge clk) begin
		if (temp_we) temp_mem[temp_wa] <= temp_wd;
		temp_rd <= temp_mem[temp_ra];
	end

	// the copy pass writes the beat read in the previous cycle
	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_wa] <= temp_rd;
		prev_rd <= prev_mem[prev_ra];
	end

	always_ff @(posedge clk) begin
		if (cx_we) cx_mem[cur_i] <= coef_v;
		cx_rd <= cx_mem[cx_ra];
	end

	always_ff @(posedge clk) begin
		if (cy_we) cy_mem[cur_i] <= coef_v;
		cy_rd <= cy_mem[cy_ra];
	end

	always_ff @(posedge clk) begin
		if (cz_we) cz_mem[cur_i] <= coef_v;
		cz_rd <= cz_mem[cz_ra];
	end

endmodule
`default_nettype wire

/* sim/jhs_checker.sv */
// Scoreboard for the 3D Jacobi heat stencil: watches the config, input and result channels,
// predicts each result in Q16.16 and compares it field by field. Depends on jhs_pkg.
`timescale 1ns / 1ps
module jhs_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  jhs_pkg::jhs_in_t              in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  jhs_pkg::jhs_out_t             out_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [jhs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output int                            errors,
	output int                            pending
);
	import jhs_pkg::*;

	localparam int CELLS = 32768;
	localparam int HALO  = 2;

	bit [31:0] dens_mem [CELLS];
	bit [31:0] ener_mem [CELLS];
	bit [31:0] base_mem [CELLS];
	bit [31:0] temp_mem [CELLS];
	bit [31:0] prev_mem [CELLS];
	bit [31:0] kx_mem [CELLS];
	bit [31:0] ky_mem [CELLS];
	bit [31:0] kz_mem [CELLS];

	int        nx, ny, nz;
	bit        recip;
	bit [31:0] scl_x, scl_y, scl_z;

	jhs_out_t  result_q[$];

	function automatic bit [31:0] eff_dens(input bit [31:0] d, inout bit flt);
		bit [127:0] q;
		if (!recip)
			return d;
		if (d == 0) begin
			flt = 1'b1;
			return 32'd0;
		end
		q = (128'd1 << 32) / d;
		return (q > 128'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
	endfunction

	function automatic bit [31:0] face_coef(input bit [31:0] s, a, b, inout bit flt);
		bit [127:0] aa, bb, ss, den, q;
		aa = a;
		bb = b;
		ss = s;
		den = aa * bb * 2;
		if (den == 0) begin
			flt = 1'b1;
			return 32'd0;
		end
		q = ((ss * (aa + bb)) << 16) / den;
		return (q > 128'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
	endfunction

	function automatic logic signed [127:0] flux(input bit [31:0] k, r);
		logic signed [127:0] kv, rv;
		kv = k;
		rv = $signed(r);
		return kv * rv;
	endfunction

	function automatic bit grid_init();
		int page, i, x, y, z;
		bit [63:0] p;
		bit flt;
		bit [31:0] ec, el, ed, eb;
		flt = 1'b0;
		page = nx * ny;
		for (z = 1; z < nz - 1; z++)
			for (y = 1; y < ny - 1; y++)
				for (x = 1; x < nx - 1; x++) begin
					i = z * page + y * nx + x;
					p = (64'(ener_mem[i]) * 64'(dens_mem[i])) >> 16;
					base_mem[i] = (p > 64'h7FFFFFFF) ? 32'h7FFFFFFF : p[31:0];
					temp_mem[i] = base_mem[i];
				end
		for (z = HALO; z < nz - 1; z++)
			for (y = HALO; y < ny - 1; y++)
				for (x = HALO; x < nx - 1; x++) begin
					i = z * page + y * nx + x;
					ec = eff_dens(dens_mem[i], flt);
					el = eff_dens(dens_mem[i - 1], flt);
					ed = eff_dens(dens_mem[i - nx], flt);
					eb = eff_dens(dens_mem[i - page], flt);
					kx_mem[i] = face_coef(scl_x, el, ec, flt);
					ky_mem[i] = face_coef(scl_y, ed, ec, flt);
					kz_mem[i] = face_coef(scl_z, eb, ec, flt);
				end
		return flt;
	endfunction

	function automatic bit [47:0] grid_sweep();
		int page, i, x, y, z;
		logic signed [127:0] tot, den, q;
		bit [127:0] dsum;
		longint nv, ov;
		bit [63:0] diff, err;
		bit [31:0] nu;
		page = nx * ny;
		err = 0;
		for (i = 0; i < nx * ny * nz; i++)
			prev_mem[i] = temp_mem[i];
		for (z = HALO; z < nz - HALO; z++)
			for (y = HALO; y < ny - HALO; y++)
				for (x = HALO; x < nx - HALO; x++) begin
					i = z * page + y * nx + x;
					tot = $signed(base_mem[i]);
					tot = tot * 65536;
					tot = tot + flux(kx_mem[i + 1], prev_mem[i + 1])
						+ flux(kx_mem[i], prev_mem[i - 1])
						+ flux(ky_mem[i + nx], prev_mem[i + nx])
						+ flux(ky_mem[i], prev_mem[i - nx])
						+ flux(kz_mem[i + page], prev_mem[i + page])
						+ flux(kz_mem[i], prev_mem[i - page]);
					dsum = 128'd65536 + kx_mem[i] + kx_mem[i + 1] + ky_mem[i]
						+ ky_mem[i + nx] + kz_mem[i] + kz_mem[i + page];
					den = dsum;
					q = tot / den;
					if (q > 2147483647)
						q = 2147483647;
					if (q < -128'sd2147483648)
						q = -128'sd2147483648;
					nu = q[31:0];
					temp_mem[i] = nu;
					nv = $signed(nu);
					ov = $signed(prev_mem[i]);
					diff = (nv >= ov) ? 64'(nv - ov) : 64'(ov - nv);
					err = (err + diff > 64'hFFFFFFFFFFFF) ? 64'hFFFFFFFFFFFF : err + diff;
				end
		return err[47:0];
	endfunction

	function automatic jhs_out_t predict(input jhs_in_t it);
		jhs_out_t r;
		bit fits;
		r = '0;
		fits = (longint'(nx) * ny * nz) <= CELLS;
		case (it.action)
			ACT_LOAD: begin
				dens_mem[it.cell_index] = it.density;
				ener_mem[it.cell_index] = it.energy;
			end
			ACT_INIT: if (fits) r.fault = grid_init();
			ACT_SWEEP: if (fits) r.error_sum = grid_sweep();
			default: r.read_value = temp_mem[it.cell_index];
		endcase
		return r;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		nx = 32;
		ny = 32;
		nz = 32;
		recip = 1'b0;
		scl_x = 32'h10000;
		scl_y = 32'h10000;
		scl_z = 32'h10000;
	end

	always @(posedge clk) begin
		jhs_out_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				case (cfg_index)
					CFG_SIZE_X:  nx = cfg_data[5:0];
					CFG_SIZE_Y:  ny = cfg_data[5:0];
					CFG_SIZE_Z:  nz = cfg_data[5:0];
					CFG_RECIP:   recip = cfg_data[0];
					CFG_SCALE_X: scl_x = cfg_data;
					CFG_SCALE_Y: scl_y = cfg_data;
					CFG_SCALE_Z: scl_z = cfg_data;
					default: ;
				endcase
			if (in_valid && in_ready)
				result_q.push_back(predict(in_data));
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("unexpected result beat");
					errors++;
				end else begin
					want = result_q.pop_front();
					if (out_data.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							want.read_value, out_data.read_value);
						errors++;
					end
					if (out_data.error_sum !== want.error_sum) begin
						$error("error_sum: expected %0d, got %0d",
							want.error_sum, out_data.error_sum);
						errors++;
					end
					if (out_data.fault !== want.fault) begin
						$error("fault: expected %0d, got %0d", want.fault, out_data.fault);
						errors++;
					end
				end
			end
			pending = result_q.size();
		end
	end

endmodule

/* sim/tb_top.sv */
// Top of the heat stencil testbench: clock, reset, config writes, load/init/sweep/read
// stimulus over several grid settings, and the verdict. Depends on jhs_pkg, jhs_checker and jacobi_heat_stencil_3d.
`timescale 1ns / 1ps
module tb_top;
	import jhs_pkg::*;

	localparam int CELLS   = 32768;
	localparam int STALL_LIMIT = 1000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	jhs_in_t              in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	jhs_out_t             out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;
	int                   errors, pending;

	int  send_idle, recv_idle, hold_left, quiet;
	int  gx, gy, gz, last_ok;
	bit  temp_ok [CELLS];

	jacobi_heat_stencil_3d u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	jhs_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else
			out_ready = ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic bit [31:0] pick_val();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(32'h40000);
			2: return 32'h8000 + $urandom_range(32'h20000);
			3: return $urandom_range(1) ? 32'hFFFFFFFF : 32'h1;
			default: return 32'h10000 + $urandom_range(255);
		endcase
	endfunction

	task automatic send_beat(input logic [1:0] act, input int idx,
			input bit [31:0] d, input bit [31:0] e);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data.action = act;
		in_data.cell_index = idx[14:0];
		in_data.density = d;
		in_data.energy = e;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] v);
		@(negedge clk);
		in_valid = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic read_interior();
		int x, y, z, idx;
		idx = -1;
		if (gx >= 3 && gy >= 3 && gz >= 3) begin
			x = $urandom_range(gx - 2, 1);
			y = $urandom_range(gy - 2, 1);
			z = $urandom_range(gz - 2, 1);
			idx = z * gx * gy + y * gx + x;
		end
		// fall back to a cell that init has already written
		if (idx < 0 || idx >= CELLS || !temp_ok[idx])
			idx = last_ok;
		if (idx >= 0)
			send_beat(ACT_READ, idx, $urandom, $urandom);
	endtask

	task automatic mark_init();
		int x, y, z;
		if (gx * gy * gz <= CELLS)
			for (z = 1; z < gz - 1; z++)
				for (y = 1; y < gy - 1; y++)
					for (x = 1; x < gx - 1; x++) begin
						temp_ok[z * gx * gy + y * gx + x] = 1'b1;
						last_ok = z * gx * gy + y * gx + x;
					end
	endtask

	task automatic run_grid(input int x, y, z, input bit rc,
			input bit [31:0] s0, s1, s2, input int sweeps, input bit squeeze);
		int i, j, k, n;
		n = x * y * z;
		drain();
		gx = x;
		gy = y;
		gz = z;
		write_reg(CFG_SIZE_X, x);
		write_reg(CFG_SIZE_Y, y);
		write_reg(CFG_SIZE_Z, z);
		write_reg(CFG_RECIP, rc);
		write_reg(CFG_SCALE_X, s0);
		write_reg(CFG_SCALE_Y, s1);
		write_reg(CFG_SCALE_Z, s2);
		if (n <= CELLS) begin
			// load every cell that init reads: everything inside the outermost layer
			for (k = 1; k < z - 1; k++)
				for (j = 1; j < y - 1; j++)
					for (i = 1; i < x - 1; i++)
						send_beat(ACT_LOAD, k * x * y + j * x + i, pick_val(), pick_val());
			// zero density inside the coefficient region: divide by zero in recip mode
			if (rc && x >= 4 && y >= 4 && z >= 4)
				send_beat(ACT_LOAD, 2 * x * y + 2 * x + 2, 32'd0, pick_val());
		end
		if (squeeze) begin
			hold_left = 400;
			for (k = 0; k < 6; k++)
				read_interior();
			send_beat(ACT_LOAD, CELLS - 1, pick_val(), pick_val());
		end
		drain();
		send_beat(ACT_INIT, $urandom, $urandom, $urandom);
		mark_init();
		for (k = 0; k < sweeps; k++) begin
			send_beat(ACT_SWEEP, $urandom, $urandom, $urandom);
			read_interior();
			read_interior();
			if ($urandom_range(3) == 0)
				send_beat(ACT_LOAD, $urandom_range(CELLS - 1), pick_val(), pick_val());
		end
	endtask

	initial begin
		hold_left = 0;
		quiet = 0;
		last_ok = -1;
		send_idle = 25;
		recv_idle = 64;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: far-end indexes, all actions, default scales
		run_grid(5, 5, 5, 1'b0, 32'h10000, 32'h10000, 32'h10000, 2, 1'b0);
		send_beat(ACT_LOAD, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_beat(ACT_LOAD, CELLS - 1, 32'h0, 32'h0);
		send_beat(ACT_LOAD, 16384, 32'hAAAAAAAA, 32'h55555555);
		send_beat(ACT_LOAD, 21845, 32'h55555555, 32'hAAAAAAAA);
		read_interior();

		send_idle = 64;
		recv_idle = 25;
		run_grid(4, 5, 5, 1'b1, 32'hFFFFFFFF, 32'h0, 32'h1, 1, 1'b0);
		run_grid(63, 63, 63, 1'b0, 32'h10000, 32'h10000, 32'h10000, 1, 1'b0);

		send_idle = 0;
		recv_idle = 0;
		run_grid(5, 6, 5, 1'b1, $urandom, $urandom_range(32'h30000), 32'h8000, 2, 1'b1);

		drain();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* jacobi_heat_stencil_3d.f */
rtl/core/jhs_pkg.sv
rtl/core/jhs_mul.sv
rtl/core/jhs_div.sv
rtl/core/jacobi_heat_stencil_3d.sv
sim/jhs_checker.sv
sim/tb_top.sv
